### sv/json_string_unescaper_macros.svh
// assertion macros for the json string unescaper checker
// expects clk and rst_n in the scope where a macro is used
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define JSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu check failed");

// next-cycle implication, disabled while reset is active
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu check failed");

`endif

### sv/jsu_pkg.sv
// shared constants, status codes and helpers for the json string unescaper
// no dependencies
package jsu_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned CP_W     = 16;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // status codes
    localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_END   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOKEN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CTRL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNI   = 3'd5;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_LAST = 8'd31;
    localparam logic [7:0] CH_BS_OUT = 8'h08;
    localparam logic [7:0] CH_FF_OUT = 8'h0C;
    localparam logic [7:0] CH_LF_OUT = 8'h0A;
    localparam logic [7:0] CH_CR_OUT = 8'h0D;
    localparam logic [7:0] CH_HT_OUT = 8'h09;

    // hex digit decode, valid bit in the top position
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

### sv/json_string_unescaper.sv
// Unescapes a JSON string literal delivered one raw byte per item and emits
// the decoded content bytes. Depends on jsu_pkg.
//
// One input item is taken per clock cycle while the result buffer has room.
// Each item is decoded in a single pass straight into a small result buffer
// of up to three entries, which drives the output stream from the cycle after
// the item is accepted. Items that give one result keep a rate of one item per
// cycle while the output side is ready; the final hex digit of a \uXXXX escape
// gives two or three UTF-8 bytes, and the input then waits while the buffer
// drains, one result per cycle while the output side is ready. Every input item
// gives at least one result; only the last result of an item has tlast set, and
// only it carries status and error position. Status and error position are zero
// on every other result, and out_byte is zero when tuser (has_byte) is low.
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] input_ended
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status,
                                                  // [34:11] error_position, rest zero
    output logic                  m_axis_tuser,   // [0] has_byte
    output logic                  m_axis_tlast    // last_of_run
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TEXT,
        PH_ESC,
        PH_HEX
    } phase_t;

    // parser state
    phase_t            phase_reg, phase_next;
    logic [CP_W-1:0]   hex_val_reg, hex_val_next;
    logic [1:0]        hex_cnt_reg, hex_cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    // result buffer
    logic [BYTE_W-1:0]   res_byte_reg [3];
    logic [1:0]          res_cnt_reg;
    logic                res_has_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [POS_W-1:0]    res_pos_reg;

    // results computed for the incoming item
    logic [1:0]          r_cnt;
    logic [BYTE_W-1:0]   r_byte [3];
    logic                r_has;
    logic [STATUS_W-1:0] r_status;
    logic [POS_W-1:0]    r_pos;

    logic [BYTE_W-1:0] c;
    logic              ended;
    logic [POS_W-1:0]  pos_inc;
    logic [4:0]        dig;
    logic [CP_W-1:0]   cp;
    logic [BYTE_W-1:0] esc_val;
    logic              esc_ok;
    logic              in_acc;
    logic              out_acc;

    assign c     = s_axis_tdata;
    assign ended = s_axis_tuser;

    // handshakes
    assign s_axis_tready = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    assign pos_inc = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_W'(1);
    assign dig     = hex_digit(c);
    assign cp      = {hex_val_reg[CP_W-5:0], dig[3:0]};

    // simple escape letters
    always_comb
    begin
        esc_ok  = 1'b1;
        esc_val = c;
        unique case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = c;
            CH_B:    esc_val = CH_BS_OUT;
            CH_F:    esc_val = CH_FF_OUT;
            CH_N:    esc_val = CH_LF_OUT;
            CH_R:    esc_val = CH_CR_OUT;
            CH_T:    esc_val = CH_HT_OUT;
            default: esc_ok  = 1'b0;
        endcase
    end

    // decode of one item
    always_comb
    begin
        phase_next   = phase_reg;
        hex_val_next = hex_val_reg;
        hex_cnt_next = hex_cnt_reg;
        pos_next     = pos_reg;
        r_cnt        = 2'd1;
        r_byte[0]    = '0;
        r_byte[1]    = '0;
        r_byte[2]    = '0;
        r_has        = 1'b0;
        r_status     = ST_BUSY;
        r_pos        = '0;

        if (ended)
        begin
            r_status = ST_END;
            r_pos    = (phase_reg == PH_IDLE) ? '0 : pos_reg;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (c != CH_QUOTE)
                        r_status = ST_TOKEN;
                    else
                    begin
                        phase_next = PH_TEXT;
                        pos_next   = POS_W'(1);
                    end
                end
                PH_TEXT:
                begin
                    if (c == CH_QUOTE)
                        r_status = ST_DONE;
                    else if (c <= CTRL_LAST)
                    begin
                        r_status = ST_CTRL;
                        r_pos    = pos_reg;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        if (c == CH_BSLASH)
                            phase_next = PH_ESC;
                        else
                        begin
                            r_has     = 1'b1;
                            r_byte[0] = c;
                        end
                    end
                end
                PH_ESC:
                begin
                    if (c == CH_U)
                    begin
                        phase_next   = PH_HEX;
                        hex_val_next = '0;
                        hex_cnt_next = '0;
                        pos_next     = pos_inc;
                    end
                    else if (esc_ok)
                    begin
                        phase_next = PH_TEXT;
                        pos_next   = pos_inc;
                        r_has      = 1'b1;
                        r_byte[0]  = esc_val;
                    end
                    else
                    begin
                        r_status = ST_TOKEN;
                        r_pos    = pos_reg;
                    end
                end
                PH_HEX:
                begin
                    if (!dig[4])
                    begin
                        r_status = ST_TOKEN;
                        r_pos    = pos_reg;
                    end
                    else if (hex_cnt_reg != 2'd3)
                    begin
                        hex_val_next = cp;
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                        pos_next     = pos_inc;
                    end
                    else if (cp[15:11] == 5'b11011)
                    begin
                        // surrogate range, reported at the 'u'
                        r_status = ST_UNI;
                        r_pos    = (pos_reg == POS_MAX) ? POS_MAX : pos_reg - POS_W'(4);
                    end
                    else
                    begin
                        phase_next   = PH_TEXT;
                        hex_val_next = '0;
                        hex_cnt_next = '0;
                        pos_next     = pos_inc;
                        r_has        = 1'b1;
                        // utf-8 encoding
                        if (cp < 16'h0080)
                            r_byte[0] = cp[7:0];
                        else if (cp < 16'h0800)
                        begin
                            r_cnt     = 2'd2;
                            r_byte[0] = {3'b110, cp[10:6]};
                            r_byte[1] = {2'b10, cp[5:0]};
                        end
                        else
                        begin
                            r_cnt     = 2'd3;
                            r_byte[0] = {4'b1110, cp[15:12]};
                            r_byte[1] = {2'b10, cp[11:6]};
                            r_byte[2] = {2'b10, cp[5:0]};
                        end
                    end
                end
            endcase
        end

        // any final status returns to idle
        if (r_status != ST_BUSY)
        begin
            phase_next   = PH_IDLE;
            hex_val_next = '0;
            hex_cnt_next = '0;
            pos_next     = '0;
        end
    end

    // parser state and result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hex_val_reg    <= '0;
            hex_cnt_reg    <= '0;
            pos_reg        <= '0;
            res_cnt_reg    <= '0;
            res_has_reg    <= 1'b0;
            res_status_reg <= ST_BUSY;
            res_pos_reg    <= '0;
            res_byte_reg[0] <= '0;
            res_byte_reg[1] <= '0;
            res_byte_reg[2] <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg       <= phase_next;
                hex_val_reg     <= hex_val_next;
                hex_cnt_reg     <= hex_cnt_next;
                pos_reg         <= pos_next;
                res_cnt_reg     <= r_cnt;
                res_has_reg     <= r_has;
                res_status_reg  <= r_status;
                res_pos_reg     <= r_pos;
                res_byte_reg[0] <= r_byte[0];
                res_byte_reg[1] <= r_byte[1];
                res_byte_reg[2] <= r_byte[2];
            end
            else if (out_acc)
            begin
                // drain one result
                res_cnt_reg     <= res_cnt_reg - 2'd1;
                res_byte_reg[0] <= res_byte_reg[1];
                res_byte_reg[1] <= res_byte_reg[2];
                res_byte_reg[2] <= '0;
            end
        end
    end

    // output stream
    assign m_axis_tvalid = (res_cnt_reg != 2'd0);
    assign m_axis_tlast  = (res_cnt_reg == 2'd1);
    assign m_axis_tuser  = res_has_reg;
    assign m_axis_tdata  = {5'd0,
                            m_axis_tlast ? res_pos_reg : {POS_W{1'b0}},
                            m_axis_tlast ? res_status_reg : ST_BUSY,
                            res_byte_reg[0]};

endmodule

### sv/jsu_checker.sv
// port-level checks for the json string unescaper, bound to the top level
// depends on jsu_pkg and json_string_unescaper_macros.svh
`include "json_string_unescaper_macros.svh"

module jsu_checker
    import jsu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);

    // a stalled result item holds
    `JSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // results before the last of a run are utf-8 bytes with no status
    `JSU_ASSERT_NOW(a_mid_run, m_axis_tvalid && !m_axis_tlast, m_axis_tuser && m_axis_tdata[34:8] == 27'd0)

    // an item without a byte carries a zero byte
    `JSU_ASSERT_NOW(a_no_byte_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0)

    // a byte is only delivered with busy status
    `JSU_ASSERT_NOW(a_byte_busy, m_axis_tvalid && m_axis_tuser, m_axis_tdata[10:8] == ST_BUSY && m_axis_tdata[34:11] == 24'd0)

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### test/tb_json_string_unescaper.sv
// self-checking testbench for the json string unescaper: streams literals one byte per item
// and checks every decoded item against a scoreboard that decodes the same bytes on its own
// depends on jsu_pkg and json_string_unescaper
module tb_json_string_unescaper;
    timeunit 1ns;
    timeprecision 1ps;
    import jsu_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 380;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // escape letters that map to a single byte
    localparam logic [7:0] SIMPLE_ESCAPES [8] =
        '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    typedef enum logic [1:0] {PH_IDLE, PH_TEXT, PH_ESC, PH_HEX} decode_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                has_byte;
        logic                last_of_run;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    error_position;
    } unescaped_t;

    // decodes accepted bytes and holds the decoded items still to come
    class unescape_scoreboard;
        decode_phase_t     phase;
        logic [CP_W-1:0]   hex_acc;
        logic [1:0]        hex_digits;
        logic [POS_W-1:0]  byte_pos;
        unescaped_t        expected_q[$];
        int unsigned       errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            phase      = PH_IDLE;
            hex_acc    = '0;
            hex_digits = '0;
            byte_pos   = '0;
        endfunction

        // value of a hex digit in either case, -1 for anything else
        function int hex_nibble(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39)
                return int'(c - 8'h30);
            if (c >= 8'h61 && c <= 8'h66)
                return int'(c - 8'h61) + 10;
            if (c >= 8'h41 && c <= 8'h46)
                return int'(c - 8'h41) + 10;
            return -1;
        endfunction

        function void expect_item(logic [7:0] ob, logic has, logic last,
                                  logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos);
            unescaped_t r;
            r.out_byte       = ob;
            r.has_byte       = has;
            r.last_of_run    = last;
            r.status         = st;
            r.error_position = pos;
            expected_q.push_back(r);
        endfunction

        // final status of a literal, back to waiting for a quote
        function void end_literal(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos);
            expect_item(8'h00, 1'b0, 1'b1, st, pos);
            clear_state();
        endfunction

        function void note_input(logic [7:0] c, logic ended);
            logic [POS_W-1:0] pos;
            logic [POS_W-1:0] nxt;
            logic [7:0]       v;
            int               d;
            logic [CP_W-1:0]  cp;
            pos = byte_pos;
            nxt = (pos == POS_MAX) ? POS_MAX : pos + POS_W'(1);
            if (ended)
            begin
                end_literal(ST_END, (phase == PH_IDLE) ? {POS_W{1'b0}} : pos);
                return;
            end
            unique case (phase)
                PH_IDLE:
                begin
                    if (c != CH_QUOTE)
                    begin
                        end_literal(ST_TOKEN, '0);
                        return;
                    end
                    phase    = PH_TEXT;
                    byte_pos = POS_W'(1);
                    expect_item(8'h00, 1'b0, 1'b1, ST_BUSY, '0);
                end
                PH_TEXT:
                begin
                    if (c == CH_QUOTE)
                    begin
                        end_literal(ST_DONE, '0);
                        return;
                    end
                    if (c <= CTRL_LAST)
                    begin
                        end_literal(ST_CTRL, pos);
                        return;
                    end
                    byte_pos = nxt;
                    if (c == CH_BSLASH)
                    begin
                        phase = PH_ESC;
                        expect_item(8'h00, 1'b0, 1'b1, ST_BUSY, '0);
                    end
                    else
                    begin
                        expect_item(c, 1'b1, 1'b1, ST_BUSY, '0);
                    end
                end
                PH_ESC:
                begin
                    unique case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
                        CH_B: v = CH_BS_OUT;
                        CH_F: v = CH_FF_OUT;
                        CH_N: v = CH_LF_OUT;
                        CH_R: v = CH_CR_OUT;
                        CH_T: v = CH_HT_OUT;
                        CH_U:
                        begin
                            phase      = PH_HEX;
                            hex_acc    = '0;
                            hex_digits = '0;
                            byte_pos   = nxt;
                            expect_item(8'h00, 1'b0, 1'b1, ST_BUSY, '0);
                            return;
                        end
                        default:
                        begin
                            end_literal(ST_TOKEN, pos);
                            return;
                        end
                    endcase
                    phase    = PH_TEXT;
                    byte_pos = nxt;
                    expect_item(v, 1'b1, 1'b1, ST_BUSY, '0);
                end
                PH_HEX:
                begin
                    d = hex_nibble(c);
                    if (d < 0)
                    begin
                        end_literal(ST_TOKEN, pos);
                        return;
                    end
                    cp = {hex_acc[11:0], 4'(d)};
                    if (hex_digits != 2'd3)
                    begin
                        hex_acc    = cp;
                        hex_digits = hex_digits + 2'd1;
                        byte_pos   = nxt;
                        expect_item(8'h00, 1'b0, 1'b1, ST_BUSY, '0);
                        return;
                    end
                    // surrogates are reported at the 'u'
                    if (cp >= 16'hD800 && cp <= 16'hDFFF)
                    begin
                        end_literal(ST_UNI, (pos == POS_MAX) ? POS_MAX : pos - 24'd4);
                        return;
                    end
                    phase      = PH_TEXT;
                    hex_acc    = '0;
                    hex_digits = '0;
                    byte_pos   = nxt;
                    // utf-8 encoding in one to three items
                    if (cp < 16'h0080)
                    begin
                        expect_item(cp[7:0], 1'b1, 1'b1, ST_BUSY, '0);
                    end
                    else if (cp < 16'h0800)
                    begin
                        expect_item({3'b110, cp[10:6]}, 1'b1, 1'b0, ST_BUSY, '0);
                        expect_item({2'b10, cp[5:0]}, 1'b1, 1'b1, ST_BUSY, '0);
                    end
                    else
                    begin
                        expect_item({4'b1110, cp[15:12]}, 1'b1, 1'b0, ST_BUSY, '0);
                        expect_item({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_BUSY, '0);
                        expect_item({2'b10, cp[5:0]}, 1'b1, 1'b1, ST_BUSY, '0);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(unescaped_t got);
            unescaped_t want;
            if (expected_q.size() == 0)
            begin
                $error("item with nothing expected: out_byte %0h status %0d",
                       got.out_byte, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("has_byte", 32'(want.has_byte), 32'(got.has_byte));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("error_position", 32'(want.error_position),
                          32'(got.error_position));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic                  s_axis_tuser = 1'b0;    // [0] input_ended
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;           // [7:0] out_byte, [10:8] status,
                                                   // [34:11] error_position
    logic                  m_axis_tuser;           // [0] has_byte
    logic                  m_axis_tlast;

    unescape_scoreboard    sb = new();
    int unsigned           items_sent = 0;
    int unsigned           src_calm = 0;
    int unsigned           sink_calm = 0;
    int unsigned           sink_hold = 0;
    int unsigned           cycle_count = 0;

    json_string_unescaper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls: mostly short, a few long, with calm stretches
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (sink_calm > 0)
                sink_calm--;
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:1]:   sink_calm = $urandom_range(40, 120);
                    [2:21]:  sink_hold = $urandom_range(1, 3);
                    [22:24]: sink_hold = $urandom_range(10, 30);
                    default: ;
                endcase
            end
        end
    end

    // check every decoded item taken by the receiver
    always @(posedge clk)
    begin
        unescaped_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_byte       = m_axis_tdata[7:0];
            got.status         = m_axis_tdata[10:8];
            got.error_position = m_axis_tdata[34:11];
            got.has_byte       = m_axis_tuser;
            got.last_of_run    = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // one input item with a random gap in front of it
    task automatic send_item(input logic [7:0] c, input logic ended);
        int unsigned gap;
        gap = 0;
        if (src_calm > 0)
            src_calm--;
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:2]:   src_calm = $urandom_range(20, 60);
                [3:24]:  gap = $urandom_range(1, 3);
                [25:29]: gap = $urandom_range(8, 30);
                default: ;
            endcase
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= ended;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_input(c, ended);
        items_sent++;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // backslash, 'u' and the leading digits of a code point in mixed case
    task automatic send_unicode(input logic [CP_W-1:0] cp, input int unsigned digits);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_U, 1'b0);
        for (int i = 0; i < digits; i++)
            send_item(hex_char(cp[15 - 4 * i -: 4], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    function automatic logic [CP_W-1:0] random_code_point();
        unique case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    // one content element: plain text, high byte, simple escape or unicode escape
    task automatic send_content();
        logic [7:0] c;
        case ($urandom_range(0, 99)) inside
            [0:44]:
            begin
                do
                    c = 8'($urandom_range(8'h20, 8'h7F));
                while (c == CH_QUOTE || c == CH_BSLASH);
                send_item(c, 1'b0);
            end
            [45:59]: send_item(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
            [60:77]:
            begin
                send_item(CH_BSLASH, 1'b0);
                send_item(SIMPLE_ESCAPES[$urandom_range(0, 7)], 1'b0);
            end
            default: send_unicode(random_code_point(), 4);
        endcase
    endtask

    // a literal with random content, mostly closed, sometimes broken off by a fault
    task automatic send_literal();
        int unsigned len;
        int unsigned r;
        logic [7:0]  c;
        send_item(CH_QUOTE, 1'b0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 8);
        repeat (len) send_content();
        r = $urandom_range(0, 99);
        if (r < 80)
            send_item(CH_QUOTE, 1'b0);
        else
        begin
            unique case (r % 5)
                0: send_item(8'($urandom_range(0, 31)), 1'b0);
                1:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F,
                                     CH_N, CH_R, CH_T, CH_U});
                    send_item(CH_BSLASH, 1'b0);
                    send_item(c, 1'b0);
                end
                2:
                begin
                    send_unicode(random_code_point(), $urandom_range(0, 3));
                    do
                        c = 8'($urandom_range(0, 255));
                    while (sb.hex_nibble(c) >= 0);
                    send_item(c, 1'b0);
                end
                3: send_unicode(16'($urandom_range(16'hD800, 16'hDFFF)), 4);
                default: send_item(8'($urandom_range(0, 255)), 1'b1);
            endcase
        end
    endtask

    initial
    begin
        int unsigned random_start;
        logic [7:0]  c;

        // reset
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // stray byte and end of input while waiting for a quote
        send_item(8'h78, 1'b0);
        send_item(8'hA5, 1'b1);
        // high byte, widest unicode escape, closing quote
        send_item(CH_QUOTE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_unicode(16'hFFFF, 4);
        send_item(CH_QUOTE, 1'b0);
        // unescaped control byte
        send_item(CH_QUOTE, 1'b0);
        send_item(8'h1F, 1'b0);
        // surrogate code point
        send_item(CH_QUOTE, 1'b0);
        send_unicode(16'hD800, 4);
        // unknown escape letter
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(8'h71, 1'b0);
        // non-hex digit in a unicode escape
        send_item(CH_QUOTE, 1'b0);
        send_unicode(16'h0000, 0);
        send_item(8'h67, 1'b0);
        // end of input inside a literal
        send_item(CH_QUOTE, 1'b0);
        send_item(8'h5A, 1'b1);

        // random literals with some noise between them
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE);
                send_item(c, 1'($urandom_range(0, 3) == 0));
            end
            send_literal();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray items
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
